>>> src/markov_chain_step_sampler_macros.svh
`ifndef MARKOV_CHAIN_STEP_SAMPLER_MACROS_SVH
`define MARKOV_CHAIN_STEP_SAMPLER_MACROS_SVH

// same-cycle implication
`define MCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcs assertion failed");

// next-cycle implication
`define MCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcs assertion failed");

`endif

>>> src/mcs_pkg.sv
package mcs_pkg;

  localparam int STATE_COUNT_DEF = 128;
  localparam int MAX_BRANCH_DEF  = 4;
  localparam int PROB_BITS       = 16;

  localparam int STATE_W  = 7;
  localparam int WEIGHT_W = 17;
  localparam int DRAW_W   = 16;
  localparam int STEP_W   = 16;

  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 16'd30;

  typedef enum logic [1:0] {
    FN_CLEAR   = 2'd0,
    FN_APPEND  = 2'd1,
    FN_STEP    = 2'd2,
    FN_RESTART = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LIMIT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    SM_IDLE,
    SM_EXEC
  } fsm_t;

endpackage

>>> src/mcs_in_if.sv
interface mcs_in_if import mcs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          func;
  logic [STATE_W-1:0]  row_state;
  logic [STATE_W-1:0]  branch_target;
  logic [WEIGHT_W-1:0] branch_weight;
  logic [DRAW_W-1:0]   random_value;

  modport source (output valid, func, row_state, branch_target, branch_weight, random_value,
                  input ready);
  modport sink   (input valid, func, row_state, branch_target, branch_weight, random_value,
                  output ready);
endinterface

>>> src/mcs_out_if.sv
interface mcs_out_if import mcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               moved;
  logic [STATE_W-1:0] from_state;
  logic [STATE_W-1:0] to_state;
  logic [STEP_W-1:0]  steps_taken;
  logic [1:0]         status;

  modport source (output valid, moved, from_state, to_state, steps_taken, status,
                  input ready);
  modport sink   (input valid, moved, from_state, to_state, steps_taken, status,
                  output ready);
endinterface

>>> src/markov_chain_step_sampler.sv
// Markov chain walker over a branch table held in one synchronous RAM, one row per state.
// Every item (clear, append, step, restart) yields exactly one result beat. The accept
// cycle issues the row read, whose result is registered; in SM_EXEC the block evaluates
// that registered row and, for an append, writes it back. SM_EXEC stretches while the
// output register still holds an untaken beat. Rows keep cumulative weights, so a step
// compares the draw against all branches of the row in parallel. A clear drops all rows
// at once through per-row valid bits; no clearing pass.
// step_limit may be written only while the block is idle.
module markov_chain_step_sampler import mcs_pkg::*; #(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int MAX_BRANCH  = MAX_BRANCH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data,
  mcs_in_if.sink            in_bus,
  mcs_out_if.source         out_bus
);

  localparam int AW   = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
  localparam int CW   = $clog2(MAX_BRANCH + 1);
  localparam int SW   = (MAX_BRANCH > 1) ? $clog2(MAX_BRANCH) : 1;
  localparam int SUMW = PROB_BITS + 1 + $clog2(MAX_BRANCH);

  localparam logic [WEIGHT_W-1:0] ONE_W   = WEIGHT_W'(1 << PROB_BITS);
  localparam logic [CW-1:0]       FULL_CNT = CW'(MAX_BRANCH);

  typedef struct packed {
    logic [STATE_W-1:0] tgt;
    logic [SUMW-1:0]    cum;
  } branch_t;

  typedef struct packed {
    logic [CW-1:0]                cnt;
    branch_t [MAX_BRANCH-1:0]     br;
  } row_t;

  row_t row_mem [STATE_COUNT];
  row_t rd_row_r;
  row_t wr_row;

  logic [STATE_COUNT-1:0] row_vld_r;

  fsm_t state_r, state_nxt;

  func_t               func_r;
  logic [AW-1:0]       addr_r;
  logic                addr_ok_r;
  logic [STATE_W-1:0]  tgt_r;
  logic [WEIGHT_W-1:0] wgt_r;
  logic [DRAW_W-1:0]   draw_r;

  logic [STATE_W-1:0] walk_state_r, walk_state_nxt;
  logic [STEP_W-1:0]  step_cnt_r, step_cnt_nxt;
  logic               stopped_r, stopped_nxt;
  logic [STEP_W-1:0]  step_limit_r;

  logic               out_valid_r;
  logic               out_moved_r;
  logic [STATE_W-1:0] out_from_r;
  logic [STATE_W-1:0] out_to_r;
  logic [STEP_W-1:0]  out_steps_r;
  status_t            out_status_r;

  logic               accept;
  logic               exec_done;
  logic [AW-1:0]      rd_addr;
  logic [STATE_W-1:0] rd_state;

  logic [CW-1:0]       eff_cnt;
  logic [CW-1:0]       last_cnt;
  logic [SW-1:0]       slot;
  logic [SW-1:0]       last_slot;
  logic [SW-1:0]       pick;
  logic [SUMW-1:0]     prev_cum;
  logic [WEIGHT_W-1:0] wgt_sat;
  logic [SUMW-1:0]     draw_ext;
  logic                mem_we;
  logic                clr_all;
  logic                set_vld;
  logic                moved;
  status_t             status;

  // fsm
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SM_IDLE: if (accept) state_nxt = SM_EXEC;
      SM_EXEC: if (exec_done) state_nxt = SM_IDLE;
      default: state_nxt = SM_IDLE;
    endcase
  end

  always_comb begin
    in_bus.ready = (state_r == SM_IDLE);
    exec_done    = (state_r == SM_EXEC) && (!out_valid_r || out_bus.ready);
  end

  assign accept   = in_bus.valid && in_bus.ready;
  assign rd_state = (func_t'(in_bus.func) == FN_APPEND) ? in_bus.row_state : walk_state_r;
  assign rd_addr  = AW'(rd_state);

  // row evaluation
  assign eff_cnt   = (addr_ok_r && row_vld_r[addr_r]) ? rd_row_r.cnt : '0;
  assign last_cnt  = eff_cnt - CW'(1);
  assign slot      = eff_cnt[SW-1:0];
  assign last_slot = last_cnt[SW-1:0];
  assign prev_cum  = (eff_cnt == '0) ? '0 : rd_row_r.br[last_slot].cum;
  assign wgt_sat   = (wgt_r > ONE_W) ? ONE_W : wgt_r;
  assign draw_ext  = SUMW'(draw_r);

  always_comb begin
    pick = last_slot;
    for (int i = MAX_BRANCH - 1; i >= 0; i--) begin
      if ((CW'(i) < eff_cnt) && (draw_ext <= rd_row_r.br[i].cum)) begin
        pick = SW'(i);
      end
    end
  end

  always_comb begin
    walk_state_nxt = walk_state_r;
    step_cnt_nxt   = step_cnt_r;
    stopped_nxt    = stopped_r;
    moved          = 1'b0;
    status         = ST_OK;
    mem_we         = 1'b0;
    clr_all        = 1'b0;
    set_vld        = 1'b0;
    wr_row         = rd_row_r;
    unique case (func_r)
      FN_CLEAR: begin
        clr_all = 1'b1;
      end
      FN_APPEND: begin
        if (!addr_ok_r || (eff_cnt >= FULL_CNT)) begin
          status = ST_FULL;
        end else begin
          mem_we               = 1'b1;
          set_vld              = 1'b1;
          wr_row.cnt           = eff_cnt + CW'(1);
          wr_row.br[slot].tgt  = tgt_r;
          wr_row.br[slot].cum  = prev_cum + SUMW'(wgt_sat);
        end
      end
      FN_STEP: begin
        priority if (stopped_r) begin
          status = (step_cnt_r >= step_limit_r) ? ST_LIMIT : ST_EMPTY;
        end else if (step_cnt_r >= step_limit_r) begin
          stopped_nxt = 1'b1;
          status      = ST_LIMIT;
        end else if (eff_cnt == '0) begin
          stopped_nxt = 1'b1;
          status      = ST_EMPTY;
        end else begin
          walk_state_nxt = rd_row_r.br[pick].tgt;
          step_cnt_nxt   = step_cnt_r + STEP_W'(1);
          moved          = 1'b1;
        end
      end
      FN_RESTART: begin
        walk_state_nxt = '0;
        step_cnt_nxt   = '0;
        stopped_nxt    = 1'b0;
      end
      default: status = ST_OK;
    endcase
  end

  // row RAM
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_row_r <= row_mem[rd_addr];
    end
    if (exec_done && mem_we) begin
      row_mem[addr_r] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r    <= func_t'(in_bus.func);
      addr_r    <= rd_addr;
      addr_ok_r <= (32'(rd_state) < 32'(STATE_COUNT));
      tgt_r     <= in_bus.branch_target;
      wgt_r     <= in_bus.branch_weight;
      draw_r    <= in_bus.random_value;
    end
    if (exec_done) begin
      out_moved_r  <= moved;
      out_from_r   <= walk_state_r;
      out_to_r     <= walk_state_nxt;
      out_steps_r  <= step_cnt_nxt;
      out_status_r <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SM_IDLE;
      walk_state_r <= '0;
      step_cnt_r   <= '0;
      stopped_r    <= 1'b0;
      row_vld_r    <= '0;
      step_limit_r <= STEP_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        step_limit_r <= cfg_wr_data;
      end
      if (exec_done) begin
        walk_state_r <= walk_state_nxt;
        step_cnt_r   <= step_cnt_nxt;
        stopped_r    <= stopped_nxt;
        if (clr_all) begin
          row_vld_r <= '0;
        end else if (set_vld) begin
          row_vld_r[addr_r] <= 1'b1;
        end
      end
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.moved       = out_moved_r;
  assign out_bus.from_state  = out_from_r;
  assign out_bus.to_state    = out_to_r;
  assign out_bus.steps_taken = out_steps_r;
  assign out_bus.status      = out_status_r;

endmodule

>>> src/mcs_checker.sv
`include "markov_chain_step_sampler_macros.svh"

module mcs_checker import mcs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_moved,
  input logic [STATE_W-1:0] out_from_state,
  input logic [STATE_W-1:0] out_to_state,
  input logic [STEP_W-1:0]  out_steps_taken,
  input logic [1:0]         out_status
);

  logic out_beat;

  assign out_beat = out_valid && out_ready;

  // one item in flight: no accept right after an accept
  `MCS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // a move is always a clean step with a nonzero count
  `MCS_ASSERT_IMP(a_moved_ok, clk, rst_n, out_beat && out_moved,
    (out_status == ST_OK) && (out_steps_taken != '0))

  // stops and dropped appends leave the walk where it was
  `MCS_ASSERT_IMP(a_stop_no_move, clk, rst_n, out_beat && (out_status != ST_OK),
    !out_moved && (out_from_state == out_to_state))

  `MCS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind markov_chain_step_sampler mcs_checker u_mcs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_moved       (out_bus.moved),
  .out_from_state  (out_bus.from_state),
  .out_to_state    (out_bus.to_state),
  .out_steps_taken (out_bus.steps_taken),
  .out_status      (out_bus.status)
);
